// File: design/assert_macros.svh
// Assertion helpers used by valve_distortion_shaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("valve shaper check failed");

// Consequent must hold in the cycle after the antecedent.
`define VDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("valve shaper check failed");

`endif

// File: design/vds_pkg.sv
// ----------------------------------------------------------------------------
// vds_pkg
// Widths, constants, state encoding and unit interfaces of the valve shaper.
// ----------------------------------------------------------------------------
package vds_pkg;

    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int HEADROOM_BITS_DEF = 3;

    // Fraction bits of the internal fixed-point values.
    localparam int FB  = 32;
    // Unsigned value width: holds the capped quotient 65536.0.
    localparam int VW  = 49;
    // Divider remainder and divisor width.
    localparam int DW  = 41;
    // Quotient bits produced by the divider.
    localparam int QB  = 48;
    localparam int XW  = 34;
    localparam int DSW = 36;
    localparam int AW  = 40;
    localparam int FXW = 50;
    localparam int KW  = 6;
    localparam int NW  = 4;
    localparam int CFG_IW = 8;
    localparam int CFG_DW = 16;
    localparam int KNOB_W = 15;

    localparam logic [FB-1:0] Q32_LN2   = 32'd2977044472;
    localparam logic [FB-1:0] Q32_0P999 = 32'd4290672329;
    localparam logic [FB-1:0] Q32_0P1   = 32'd429496730;
    localparam logic [FB:0]   Q32_ONE   = 33'h1_0000_0000;

    localparam logic [KW-1:0]     EXP_K_LIMIT  = 6'd40;
    localparam logic [NW-1:0]     SERIES_TERMS = 4'd14;
    localparam logic [KNOB_W-1:0] KNOB_RESET   = 15'd16384;

    localparam logic [CFG_IW-1:0] REG_LEVEL     = 8'd0;
    localparam logic [CFG_IW-1:0] REG_CHARACTER = 8'd1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RCP_GO,
        ST_RCP_WAIT,
        ST_CRV_GO,
        ST_MAG_WAIT,
        ST_KDIV_GO,
        ST_KDIV_WAIT,
        ST_SMUL_GO,
        ST_SMUL_WAIT,
        ST_SDIV_GO,
        ST_SDIV_WAIT,
        ST_SHIFT,
        ST_DEN,
        ST_NMUL_GO,
        ST_NMUL_WAIT,
        ST_QDIV_GO,
        ST_QDIV_WAIT,
        ST_CRV_DONE,
        ST_FXO,
        ST_FILT_GO,
        ST_FILT_WAIT,
        ST_FINISH
    } st_t;

    typedef struct packed {
        logic          start;
        logic [VW-1:0] a;
        logic [VW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic          done;
        logic [VW-1:0] prod;
    } mul_res_t;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] hi;
        logic [QB-1:0] lo;
        logic [DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [VW-1:0] quot;
        logic [DW-1:0] rem;
    } div_res_t;

endpackage

// File: design/vds_mul.sv
// ----------------------------------------------------------------------------
// vds_mul
// Bit-serial multiplier giving floor(a * b / 2^32), one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module vds_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  vds_pkg::mul_req_t  req,
    output vds_pkg::mul_res_t  res
);
    import vds_pkg::*;

    localparam int CW = $clog2(VW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [VW-1:0]     a_reg, a_next;
    logic [VW-1:0]     b_reg, b_next;
    logic [2*VW-1:0]   acc_reg, acc_next;

    // Multiplier bits are consumed from the top, so the accumulator doubles
    // before each partial product is added.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(VW - 1);
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = {acc_reg[2*VW-2:0], 1'b0}
                     + (b_reg[VW-1] ? {{VW{1'b0}}, a_reg} : {(2*VW){1'b0}});
            b_next   = {b_reg[VW-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign res.done = done_reg;
    assign res.prod = acc_reg[FB+VW-1:FB];

endmodule

// File: design/vds_div.sv
// ----------------------------------------------------------------------------
// vds_div
// Restoring divider, one quotient bit a cycle, with saturation of the quotient.
// ----------------------------------------------------------------------------
module vds_div (
    input  logic               clk,
    input  logic               rst_n,
    input  vds_pkg::div_req_t  req,
    output vds_pkg::div_res_t  res
);
    import vds_pkg::*;

    localparam int CW = $clog2(QB);
    localparam logic [VW-1:0] QUOT_CAP = VW'(1) << QB;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            cap_reg, cap_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [QB-1:0]   q_reg, q_next;
    logic [DW:0]     shifted;
    logic            fits;

    // The dividend is hi * 2^48 + lo. Its low word shifts out of q_reg while
    // quotient bits shift in behind it. When hi already reaches the divisor
    // the quotient would need more than 48 bits and is capped instead.
    always_comb begin
        shifted   = {rem_reg, q_reg[QB-1]};
        fits      = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cap_next  = cap_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (req.start) begin
            den_next = req.den;
            rem_next = req.hi;
            q_next   = req.lo;
            cnt_next = CW'(QB - 1);
            if (req.hi >= req.den) begin
                cap_next  = 1'b1;
                done_next = 1'b1;
            end else begin
                cap_next  = 1'b0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = fits ? DW'(shifted - {1'b0, den_reg}) : shifted[DW-1:0];
            q_next   = {q_reg[QB-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        cap_reg <= cap_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign res.done = done_reg;
    assign res.quot = cap_reg ? QUOT_CAP : {{(VW-QB){1'b0}}, q_reg};
    assign res.rem  = rem_reg;

endmodule

// File: design/valve_distortion_shaper.sv
// ----------------------------------------------------------------------------
// valve_distortion_shaper
// Valve-style waveshaper on each audio word, followed by a DC blocking filter.
// ----------------------------------------------------------------------------
// Usage: audio words enter on the s_ stream channel, one signed sample in
// s_tdata with s_tlast marking the last sample of a block; after such a
// sample the filter history is clamped to plus or minus 1.0. Each input word
// produces exactly one output word on the m_ channel. The level and character
// knobs are written through the cfg_ channel, which is always ready; write
// them only while no sample is in flight.
// Sequencing: one sample is processed at a time. Each multiply and each
// divide is done one bit per cycle by a single shared multiplier and a
// single shared divider. A full curve evaluation spends most of its time in
// the fourteen multiply and divide pairs of the exponential series; the
// series is skipped when the exponential underflows, and a curve evaluated
// exactly at the input equal to q needs neither unit. A sample needs one or
// two curve evaluations depending on the level setting.
// The next sample is taken as soon as the previous one has left the
// sequencer, even while its result still waits in the output register; a
// stalled receiver holds the sequencer in its final step only when a second
// result is ready behind the first. Reset sets both knobs to 1.0 and the
// filter history to 1.0, and leaves the output channel empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module valve_distortion_shaper #(
    parameter int SAMPLE_BITS   = vds_pkg::SAMPLE_BITS_DEF,
    parameter int HEADROOM_BITS = vds_pkg::HEADROOM_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,  // in_sample
    input  logic                                   s_tlast,  // block_end
    // Output stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_BITS+HEADROOM_BITS+7)/8)*8-1:0] m_tdata, // out_sample
    // Configuration writes.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [vds_pkg::CFG_IW-1:0]             cfg_index,
    input  logic [vds_pkg::CFG_DW-1:0]             cfg_data
);
    import vds_pkg::*;

    localparam int FRAC   = SAMPLE_BITS - 1;
    localparam int OB     = SAMPLE_BITS + HEADROOM_BITS;
    localparam int UP     = FB - FRAC;
    localparam int OUT_TW = ((OB + 7) / 8) * 8;

    localparam logic [OB-1:0]         OB_MAX   = {1'b0, {(OB-1){1'b1}}};
    localparam logic [OB-1:0]         OB_MIN   = {1'b1, {(OB-1){1'b0}}};
    localparam logic signed [OB-1:0]  ONE_S    = OB'(1) << FRAC;
    localparam logic [FXW-1:0]        RND_HALF = FXW'(1) << (UP - 1);
    localparam logic [DW-1:0]         RCP_HI   = DW'(1) << (FB - (QB - FB));

    function automatic logic signed [OB-1:0] clamp_one(input logic signed [OB-1:0] v);
        logic signed [OB-1:0] r;
        r = v;
        if (v > ONE_S) begin
            r = ONE_S;
        end else if (v < -ONE_S) begin
            r = -ONE_S;
        end
        return r;
    endfunction

    st_t state_reg, state_next;

    logic [KNOB_W-1:0]      level_reg, level_next;
    logic [KNOB_W-1:0]      char_reg, char_next;
    logic signed [XW-1:0]   x_reg, x_next;
    logic                   last_reg, last_next;
    logic [VW-1:0]          recip_reg, recip_next;
    logic                   sel_reg, sel_next;
    logic signed [DSW-1:0]  d_reg, d_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [FB-1:0]          r_reg, r_next;
    logic [FB:0]            e_reg, e_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [VW-1:0]          g_reg, g_next;
    logic signed [FXW-1:0]  fx_reg, fx_next;
    logic signed [OB-1:0]   fxo_reg, fxo_next;
    logic signed [OB-1:0]   prev_shaped_reg, prev_shaped_next;
    logic signed [OB-1:0]   prev_output_reg, prev_output_next;
    logic [OB-1:0]          out_reg, out_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    mul_req_t mul_req;
    mul_res_t mul_res;
    div_req_t div_req;
    div_res_t div_res;

    // Derived knob values and per-curve helpers.
    logic signed [DSW-1:0]  q_w;
    logic [20:0]            c40_w;
    logic [AW-1:0]          a_w;
    logic [DSW-1:0]         mag_w;
    logic [FB:0]            den_w;
    logic [VW-1:0]          num_w;
    logic                   d_pos;

    // Rounding of the shaped value and the filter sum.
    logic                   fx_neg;
    logic [FXW-1:0]         fx_mag, rsum, rmag;
    logic                   prev_neg;
    logic [OB-1:0]          pmag_w;
    logic [OB-1:0]          damp_w;
    logic signed [OB+1:0]   damp_s, y_sum;
    logic [OB-1:0]          y_sat;
    logic                   out_free;

    // Sequencer steps in which a unit result is awaited.
    logic                   mul_wait_w;
    logic                   div_wait_w;

    vds_mul u_mul (
        .clk   (aclk),
        .rst_n (aresetn),
        .req   (mul_req),
        .res   (mul_res)
    );

    vds_div u_div (
        .clk   (aclk),
        .rst_n (aresetn),
        .req   (div_req),
        .res   (div_res)
    );

    // q = level - 0.999 and a = 40 * character + 0.1, both at 32 fraction bits.
    always_comb begin
        q_w   = $signed({3'b000, level_reg, 18'b0}) - $signed({4'b0000, Q32_0P999});
        c40_w = {1'b0, char_reg, 5'b0} + {3'b000, char_reg, 3'b000};
        a_w   = {1'b0, c40_w, 18'b0} + {8'b0, Q32_0P1};
        mag_w = d_reg[DSW-1] ? DSW'(-d_reg) : DSW'(d_reg);
        d_pos = !d_reg[DSW-1];
        den_w = Q32_ONE - e_reg;
        num_w = d_pos ? VW'(mag_w) : mul_res.prod;
    end

    // Shaped value rounded half away from zero to the output fraction and
    // saturated; then the filter sum 0.999 * y_prev + fx - fx_prev.
    always_comb begin
        fx_neg   = fx_reg[FXW-1];
        fx_mag   = fx_neg ? FXW'(-fx_reg) : FXW'(fx_reg);
        rsum     = fx_mag + RND_HALF;
        rmag     = rsum >> UP;
        prev_neg = prev_output_reg[OB-1];
        pmag_w   = prev_neg ? OB'(-prev_output_reg) : OB'(prev_output_reg);
        damp_w   = mul_res.prod[OB-1:0];
        damp_s   = prev_neg ? -$signed({2'b00, damp_w}) : $signed({2'b00, damp_w});
        y_sum    = damp_s + {{2{fxo_reg[OB-1]}}, fxo_reg}
                 - {{2{prev_shaped_reg[OB-1]}}, prev_shaped_reg};
        if (y_sum[OB+1:OB-1] == 3'b000 || y_sum[OB+1:OB-1] == 3'b111) begin
            y_sat = y_sum[OB-1:0];
        end else begin
            y_sat = y_sum[OB+1] ? OB_MIN : OB_MAX;
        end
        out_free = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        level_next = level_reg;
        char_next  = char_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LEVEL:     level_next = cfg_data[KNOB_W-1:0];
                REG_CHARACTER: char_next  = cfg_data[KNOB_W-1:0];
                default:       ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_RCP_GO;
            ST_RCP_GO:    state_next = ST_RCP_WAIT;
            ST_RCP_WAIT:  if (div_res.done) state_next = ST_CRV_GO;
            ST_CRV_GO:    state_next = (d_reg == '0) ? ST_CRV_DONE : ST_MAG_WAIT;
            ST_MAG_WAIT:  if (mul_res.done) state_next = ST_KDIV_GO;
            ST_KDIV_GO:   state_next = ST_KDIV_WAIT;
            ST_KDIV_WAIT: begin
                if (div_res.done) begin
                    state_next = (div_res.quot >= VW'(EXP_K_LIMIT)) ? ST_DEN : ST_SMUL_GO;
                end
            end
            ST_SMUL_GO:   state_next = ST_SMUL_WAIT;
            ST_SMUL_WAIT: if (mul_res.done) state_next = ST_SDIV_GO;
            ST_SDIV_GO:   state_next = ST_SDIV_WAIT;
            ST_SDIV_WAIT: begin
                if (div_res.done) begin
                    state_next = (n_reg == NW'(1)) ? ST_SHIFT : ST_SMUL_GO;
                end
            end
            ST_SHIFT:     if (k_reg == '0) state_next = ST_DEN;
            ST_DEN: begin
                if (den_w == '0) begin
                    state_next = ST_CRV_DONE;
                end else begin
                    state_next = d_pos ? ST_QDIV_GO : ST_NMUL_GO;
                end
            end
            ST_NMUL_GO:   state_next = ST_NMUL_WAIT;
            ST_NMUL_WAIT: if (mul_res.done) state_next = ST_QDIV_GO;
            ST_QDIV_GO:   state_next = ST_QDIV_WAIT;
            ST_QDIV_WAIT: if (div_res.done) state_next = ST_CRV_DONE;
            ST_CRV_DONE:  state_next = (!sel_reg && q_w != '0) ? ST_CRV_GO : ST_FXO;
            ST_FXO:       state_next = ST_FILT_GO;
            ST_FILT_GO:   state_next = ST_FILT_WAIT;
            ST_FILT_WAIT: if (mul_res.done) state_next = ST_FINISH;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath updates and unit requests for each step.
    always_comb begin
        x_next           = x_reg;
        last_next        = last_reg;
        recip_next       = recip_reg;
        sel_next         = sel_reg;
        d_next           = d_reg;
        k_next           = k_reg;
        r_next           = r_reg;
        e_next           = e_reg;
        n_next           = n_reg;
        g_next           = g_reg;
        fx_next          = fx_reg;
        fxo_next         = fxo_reg;
        prev_shaped_next = prev_shaped_reg;
        prev_output_next = prev_output_reg;
        out_next         = out_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        mul_req          = '0;
        div_req          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next    = $signed({{(XW-SAMPLE_BITS){s_tdata[SAMPLE_BITS-1]}},
                                         s_tdata[SAMPLE_BITS-1:0]}) <<< UP;
                    last_next = s_tlast;
                end
            end
            ST_RCP_GO: begin
                div_req.start = 1'b1;
                div_req.hi    = RCP_HI;
                div_req.lo    = '0;
                div_req.den   = DW'(a_w);
            end
            ST_RCP_WAIT: begin
                if (div_res.done) begin
                    recip_next = div_res.quot;
                    sel_next   = 1'b0;
                    d_next     = $signed({{(DSW-XW){x_reg[XW-1]}}, x_reg}) - q_w;
                end
            end
            ST_CRV_GO: begin
                if (d_reg == '0) begin
                    g_next = recip_reg;
                end else begin
                    mul_req.start = 1'b1;
                    mul_req.a     = VW'(a_w);
                    mul_req.b     = VW'(mag_w);
                end
            end
            ST_KDIV_GO: begin
                // Range reduction: k = floor(v / ln2), r = v - k * ln2.
                div_req.start = 1'b1;
                div_req.hi    = '0;
                div_req.lo    = mul_res.prod[QB-1:0];
                div_req.den   = DW'(Q32_LN2);
            end
            ST_KDIV_WAIT: begin
                if (div_res.done) begin
                    if (div_res.quot >= VW'(EXP_K_LIMIT)) begin
                        e_next = '0;
                        k_next = '0;
                    end else begin
                        k_next = div_res.quot[KW-1:0];
                        r_next = div_res.rem[FB-1:0];
                        e_next = Q32_ONE;
                        n_next = SERIES_TERMS;
                    end
                end
            end
            ST_SMUL_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = VW'(r_reg);
                mul_req.b     = VW'(e_reg);
            end
            ST_SDIV_GO: begin
                div_req.start = 1'b1;
                div_req.hi    = '0;
                div_req.lo    = mul_res.prod[QB-1:0];
                div_req.den   = DW'(n_reg);
            end
            ST_SDIV_WAIT: begin
                if (div_res.done) begin
                    e_next = Q32_ONE - div_res.quot[FB:0];
                    if (n_reg != NW'(1)) begin
                        n_next = n_reg - NW'(1);
                    end
                end
            end
            ST_SHIFT: begin
                if (k_reg != '0) begin
                    e_next = e_reg >> 1;
                    k_next = k_reg - KW'(1);
                end
            end
            ST_DEN: begin
                // A denominator that vanishes falls back to the limit 1/a.
                if (den_w == '0) begin
                    g_next = recip_reg;
                end
            end
            ST_NMUL_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = VW'(mag_w);
                mul_req.b     = VW'(e_reg);
            end
            ST_QDIV_GO: begin
                div_req.start = 1'b1;
                div_req.hi    = DW'(num_w[VW-1:QB-FB]);
                div_req.lo    = {num_w[QB-FB-1:0], {FB{1'b0}}};
                div_req.den   = DW'(den_w);
            end
            ST_QDIV_WAIT: begin
                if (div_res.done) begin
                    g_next = div_res.quot;
                end
            end
            ST_CRV_DONE: begin
                if (!sel_reg) begin
                    fx_next = $signed({1'b0, g_reg});
                    if (q_w != '0) begin
                        sel_next = 1'b1;
                        d_next   = -q_w;
                    end
                end else begin
                    fx_next = fx_reg - $signed({1'b0, g_reg});
                end
            end
            ST_FXO: begin
                if (rmag > FXW'(OB_MAX)) begin
                    fxo_next = fx_neg ? OB_MIN : OB_MAX;
                end else begin
                    fxo_next = fx_neg ? OB'(-rmag) : OB'(rmag);
                end
            end
            ST_FILT_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = VW'(pmag_w);
                mul_req.b     = VW'(Q32_0P999);
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_next      = y_sat;
                    m_tvalid_next = 1'b1;
                    if (last_reg) begin
                        prev_shaped_next = clamp_one(fxo_reg);
                        prev_output_next = clamp_one($signed(y_sat));
                    end else begin
                        prev_shaped_next = fxo_reg;
                        prev_output_next = $signed(y_sat);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            level_reg       <= KNOB_RESET;
            char_reg        <= KNOB_RESET;
            prev_shaped_reg <= ONE_S;
            prev_output_reg <= ONE_S;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            level_reg       <= level_next;
            char_reg        <= char_next;
            prev_shaped_reg <= prev_shaped_next;
            prev_output_reg <= prev_output_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        last_reg  <= last_next;
        recip_reg <= recip_next;
        sel_reg   <= sel_next;
        d_reg     <= d_next;
        k_reg     <= k_next;
        r_reg     <= r_next;
        e_reg     <= e_next;
        n_reg     <= n_next;
        g_reg     <= g_next;
        fx_reg    <= fx_next;
        fxo_reg   <= fxo_next;
        out_reg   <= out_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_TW'(out_reg);

    assign mul_wait_w = state_reg == ST_MAG_WAIT || state_reg == ST_SMUL_WAIT
                     || state_reg == ST_NMUL_WAIT || state_reg == ST_FILT_WAIT;
    assign div_wait_w = state_reg == ST_RCP_WAIT || state_reg == ST_KDIV_WAIT
                     || state_reg == ST_SDIV_WAIT || state_reg == ST_QDIV_WAIT;

    // The shared units only report completion while the sequencer waits.
    `VDS_ASSERT_NOW(mul_done_in_wait, aclk, aresetn, mul_res.done, mul_wait_w)
    `VDS_ASSERT_NOW(div_done_in_wait, aclk, aresetn, div_res.done, div_wait_w)
    // A result word appears only from the final step of a sample.
    `VDS_ASSERT_NEXT(out_from_finish, aclk, aresetn, !m_tvalid_reg && state_reg != ST_FINISH, !m_tvalid_reg)

endmodule
